FILE: sv/ckd_pkg.sv
// Shared types, button codes and the chord keycode ROM of the chord keypad decoder.
package ckd_pkg;

   // Number of key groups that a mode toggle may select
   localparam int unsigned NUM_GROUPS = 3;
   localparam int unsigned ROM_GROUPS = 3;
   localparam int unsigned ROM_ROWS   = 7;
   localparam int unsigned ROM_COLS   = 6;

   localparam int unsigned BUTTON_W = 16;
   localparam int unsigned CODE_W   = 8;
   localparam int unsigned ROW_W    = 3;
   localparam int unsigned LAYER_W  = 2;
   localparam int unsigned FLAG_W   = 4;
   localparam int unsigned MOD_W    = 3;

   localparam logic [BUTTON_W-1:0] B_SELECT   = 16'h0001;
   localparam logic [BUTTON_W-1:0] B_START    = 16'h0008;
   localparam logic [BUTTON_W-1:0] B_UP       = 16'h0010;
   localparam logic [BUTTON_W-1:0] B_RIGHT    = 16'h0020;
   localparam logic [BUTTON_W-1:0] B_DOWN     = 16'h0040;
   localparam logic [BUTTON_W-1:0] B_LEFT     = 16'h0080;
   localparam logic [BUTTON_W-1:0] B_TRIANGLE = 16'h1000;
   localparam logic [BUTTON_W-1:0] B_CIRCLE   = 16'h2000;
   localparam logic [BUTTON_W-1:0] B_CROSS    = 16'h4000;
   localparam logic [BUTTON_W-1:0] B_SQUARE   = 16'h8000;

   // Modifier flag bit positions
   localparam int unsigned F_CTRL_BIT  = 0;
   localparam int unsigned F_SHIFT_BIT = 1;
   localparam int unsigned F_ALT_BIT   = 2;
   localparam int unsigned F_MODE_BIT  = 3;

   // Row codes: none, the six chord rows, and the row of single-press keys
   localparam logic [ROW_W-1:0] ROW_NONE     = 3'd0;
   localparam logic [ROW_W-1:0] ROW_LEFT     = 3'd1;
   localparam logic [ROW_W-1:0] ROW_UP       = 3'd2;
   localparam logic [ROW_W-1:0] ROW_RIGHT    = 3'd3;
   localparam logic [ROW_W-1:0] ROW_SQUARE   = 3'd4;
   localparam logic [ROW_W-1:0] ROW_TRIANGLE = 3'd5;
   localparam logic [ROW_W-1:0] ROW_CIRCLE   = 3'd6;
   localparam logic [ROW_W-1:0] ROW_OTHER    = 3'd7;

   // Columns of the single-press keys in the other row
   localparam logic [ROW_W-1:0] COL_DOWN   = 3'd1;
   localparam logic [ROW_W-1:0] COL_CROSS  = 3'd2;
   localparam logic [ROW_W-1:0] COL_START  = 3'd3;
   localparam logic [ROW_W-1:0] COL_SELECT = 3'd4;

   localparam logic [LAYER_W-1:0] LAYER_BASE  = 2'd0;
   localparam logic [LAYER_W-1:0] LAYER_LEFT  = 2'd1;
   localparam logic [LAYER_W-1:0] LAYER_UP    = 2'd2;

   typedef logic [CODE_W-1:0] code_type;

   localparam code_type CHORD_ROM [ROM_GROUPS][ROM_ROWS][ROM_COLS] = '{
      '{ '{8'd48, 8'd21, 8'd34, 8'd26, 8'd40, 8'd51},
         '{8'd33, 8'd24, 8'd22, 8'd45, 8'd47, 8'd41},
         '{8'd36, 8'd38, 8'd32, 8'd50, 8'd44, 8'd27},
         '{8'd43, 8'd16, 8'd25, 8'd31, 8'd20, 8'd46},
         '{8'd39, 8'd17, 8'd37, 8'd19, 8'd18, 8'd30},
         '{8'd52, 8'd12, 8'd53, 8'd35, 8'd49, 8'd23},
         '{8'd14, 8'd57, 8'd28, 8'd1,  8'd0,  8'd0 } },
      '{ '{8'd59, 8'd60, 8'd66, 8'd26, 8'd39, 8'd51},
         '{8'd61, 8'd62, 8'd63, 8'd98, 8'd88, 8'd41},
         '{8'd67, 8'd64, 8'd65, 8'd68, 8'd87, 8'd27},
         '{8'd96, 8'd55, 8'd11, 8'd2,  8'd3,  8'd10},
         '{8'd39, 8'd78, 8'd74, 8'd4,  8'd5,  8'd6 },
         '{8'd52, 8'd13, 8'd0,  8'd9,  8'd7,  8'd8 },
         '{8'd14, 8'd57, 8'd28, 8'd1,  8'd0,  8'd0 } },
      '{ '{8'd105, 8'd102, 8'd110, 8'd0,   8'd0,  8'd0 },
         '{8'd107, 8'd103, 8'd104, 8'd119, 8'd99, 8'd0 },
         '{8'd111, 8'd109, 8'd106, 8'd78,  8'd55, 8'd0 },
         '{8'd0,   8'd70,  8'd74,  8'd1,   8'd0,  8'd0 },
         '{8'd0,   8'd69,  8'd0,   8'd29,  8'd42, 8'd56},
         '{8'd97,  8'd54,  8'd100, 8'd58,  8'd0,  8'd15},
         '{8'd108, 8'd57,  8'd28,  8'd1,   8'd0,  8'd0 } }
   };

   typedef struct packed {
      logic [BUTTON_W-1:0] last_buttons;
      logic [FLAG_W-1:0]   flags;
      logic [ROW_W-1:0]    first_button;
      logic                held_pressed;
      code_type            held_code;
      logic [MOD_W-1:0]    held_mods;
      logic [LAYER_W-1:0]  layer;
      logic [ROW_W-1:0]    shown_hint;
   } ckd_state_type;

   typedef struct packed {
      logic [LAYER_W-1:0] layer_now;
      logic [ROW_W-1:0]   hint_button;
      logic               mod_alt;
      logic               mod_shift;
      logic               mod_ctrl;
      code_type           key_code;
      logic               key_press;
      logic               key_valid;
   } ckd_rsp_type;

   localparam int unsigned RSP_BITS = $bits(ckd_rsp_type);
   localparam int unsigned RSP_W    = ((RSP_BITS + 7) / 8) * 8;

   // Chord ROM read; out-of-range group, row or column reads as zero
   function automatic code_type chord_lookup(input logic [LAYER_W-1:0] grp,
                                             input logic [ROW_W-1:0] row,
                                             input logic [ROW_W-1:0] col);
      logic [ROW_W-1:0] r_idx;
      logic [ROW_W-1:0] c_idx;
      r_idx = row - 3'd1;
      c_idx = col - 3'd1;
      if ((32'(grp) >= ROM_GROUPS) || (row == ROW_NONE) || (col == 3'd0) || (col == 3'd7)) begin
         return '0;
      end
      return CHORD_ROM[grp][r_idx][c_idx];
   endfunction

   // Chord row of a single button, none for anything else
   function automatic logic [ROW_W-1:0] row_of(input logic [BUTTON_W-1:0] b);
      logic [ROW_W-1:0] r;
      unique case (b)
         B_LEFT:     r = ROW_LEFT;
         B_UP:       r = ROW_UP;
         B_RIGHT:    r = ROW_RIGHT;
         B_SQUARE:   r = ROW_SQUARE;
         B_TRIANGLE: r = ROW_TRIANGLE;
         B_CIRCLE:   r = ROW_CIRCLE;
         default:    r = ROW_NONE;
      endcase
      return r;
   endfunction

endpackage

FILE: sv/chord_keypad_decoder_top.sv
// Top level of the chord keypad decoder: poll register, decode, result register.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------------
//  req     | in  | req_tvalid/tready  | req_tdata[15:0]  buttons
//  rsp     | out | rsp_tvalid/tready  | rsp_tdata[23:0]  key event, hint, layer
//
//  Every request yields exactly one response, registered through the poll
//  register and then the result register; one request per cycle is sustained when the result side does not stall.
//  The poll register feeds the decoder, whose result and new chord state are
//  taken together in one clock edge into the result register and state.
//  A stall on rsp holds the result register and, once the poll register is
//  full too, drops req_tready; no poll is lost or processed twice.
//  Synchronous active-high reset clears chord state and both valid flags.
module chord_keypad_decoder_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [ckd_pkg::BUTTON_W-1:0] req_tdata,   // [15:0] buttons
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // [0] key_valid, [1] key_press, [9:2] key_code, [10] mod_ctrl,
   // [11] mod_shift, [12] mod_alt, [15:13] hint_button, [17:16] layer_now,
   // [23:18] zero
   output logic [ckd_pkg::RSP_W-1:0]    rsp_tdata
);
   import ckd_pkg::*;

   // Poll register
   logic                poll_valid_ff, poll_valid_in;
   logic [BUTTON_W-1:0] poll_buttons_ff, poll_buttons_in;

   // Chord state
   ckd_state_type state_ff, state_in;
   ckd_state_type state_nxt;

   // Result register
   logic        out_valid_ff, out_valid_in;
   ckd_rsp_type out_data_ff, out_data_in;
   ckd_rsp_type rsp_dec;

   logic advance;   // poll moves into the result register this cycle
   logic req_fire;

   // Result slot frees when empty or being taken
   assign advance    = poll_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !poll_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   ckd_decode u_decode (
      .buttons   (poll_buttons_ff),
      .state_cur (state_ff),
      .state_nxt (state_nxt),
      .rsp       (rsp_dec)
   );

   always_comb begin
      poll_valid_in   = poll_valid_ff;
      poll_buttons_in = poll_buttons_ff;
      state_in        = state_ff;
      out_valid_in    = out_valid_ff;
      out_data_in     = out_data_ff;

      // Drain the result once taken
      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      // Commit the decoded poll: update state, load the result
      if (advance) begin
         state_in      = state_nxt;
         out_valid_in  = 1'b1;
         out_data_in   = rsp_dec;
         poll_valid_in = 1'b0;
      end
      // Capture a new request
      if (req_fire) begin
         poll_valid_in   = 1'b1;
         poll_buttons_in = req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poll_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         state_ff      <= '0;
      end else begin
         poll_valid_ff <= poll_valid_in;
         out_valid_ff  <= out_valid_in;
         state_ff      <= state_in;
      end
   end

   // Payload registers hold without reset
   always_ff @(posedge clock) begin
      poll_buttons_ff <= poll_buttons_in;
      out_data_ff     <= out_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_W - RSP_BITS){1'b0}}, out_data_ff};

endmodule

FILE: sv/ckd_decode.sv
// Next-state and key event logic for one button poll.
module ckd_decode (
   input  logic [ckd_pkg::BUTTON_W-1:0] buttons,
   input  ckd_pkg::ckd_state_type       state_cur,
   output ckd_pkg::ckd_state_type       state_nxt,
   output ckd_pkg::ckd_rsp_type         rsp
);
   import ckd_pkg::*;

   logic                emit;
   logic [ROW_W-1:0]    col;
   logic [FLAG_W-1:0]   flags_t;
   logic [BUTTON_W-1:0] last;
   code_type            code_new;

   assign last = state_cur.last_buttons;

   function automatic logic [LAYER_W-1:0] toggle_to(input logic [LAYER_W-1:0] cur,
                                                    input logic [LAYER_W-1:0] target);
      if ((cur == target) || (32'(target) >= NUM_GROUPS)) begin
         return LAYER_BASE;
      end
      return target;
   endfunction

   always_comb begin
      state_nxt = state_cur;
      rsp       = '0;
      emit      = 1'b0;
      col       = ROW_NONE;
      flags_t   = state_cur.flags;
      code_new  = '0;

      if (buttons == '0) begin
         // Release: key-up for a held key
         if (state_cur.held_pressed && (state_cur.first_button != ROW_NONE)) begin
            state_nxt.held_pressed = 1'b0;
            state_nxt.flags        = '0;
            state_nxt.first_button = ROW_NONE;
            rsp.key_valid          = 1'b1;
            rsp.key_code           = state_cur.held_code;
            {rsp.mod_alt, rsp.mod_shift, rsp.mod_ctrl} = state_cur.held_mods;
         end
      end else if (buttons == last) begin
         // no change
      end else if (last != '0) begin
         // Change while buttons are held: an added button sets a modifier or the mode flag
         if ((last & buttons) != buttons) begin
            unique case (buttons ^ last)
               B_DOWN, B_CROSS:   flags_t[F_MODE_BIT]  = 1'b1;
               B_RIGHT, B_CIRCLE: flags_t[F_ALT_BIT]   = 1'b1;
               B_SQUARE, B_LEFT:  flags_t[F_CTRL_BIT]  = 1'b1;
               B_TRIANGLE, B_UP:  flags_t[F_SHIFT_BIT] = 1'b1;
               default: ;
            endcase
         end
         state_nxt.flags = flags_t;
         if (flags_t[F_MODE_BIT]) begin
            if (last == B_LEFT) begin
               state_nxt.layer = toggle_to(state_cur.layer, LAYER_LEFT);
            end else if (last == B_UP) begin
               state_nxt.layer = toggle_to(state_cur.layer, LAYER_UP);
            end
            state_nxt.flags        = '0;
            state_nxt.first_button = ROW_NONE;
            state_nxt.shown_hint   = ROW_NONE;
         end
      end else if (state_cur.first_button != ROW_NONE) begin
         // Second press picks the column
         state_nxt.shown_hint = ROW_NONE;
         col = row_of(buttons);
         if (col == ROW_NONE) begin
            state_nxt.flags        = '0;
            state_nxt.first_button = ROW_NONE;
         end else begin
            emit = 1'b1;
         end
      end else begin
         // First press: arm a row or fire a single-press key
         unique case (buttons)
            B_START: begin
               state_nxt.first_button = ROW_OTHER;
               col = COL_START;
            end
            B_SELECT: begin
               state_nxt.first_button = ROW_OTHER;
               col = COL_SELECT;
            end
            B_DOWN: begin
               state_nxt.first_button = ROW_OTHER;
               col = COL_DOWN;
            end
            B_CROSS: begin
               state_nxt.first_button = ROW_OTHER;
               col = COL_CROSS;
            end
            default: state_nxt.first_button = row_of(buttons);
         endcase
         if (state_nxt.first_button == ROW_OTHER) begin
            emit = 1'b1;
         end else begin
            state_nxt.shown_hint = state_nxt.first_button;
         end
      end

      if (emit) begin
         code_new               = chord_lookup(state_cur.layer, state_nxt.first_button, col);
         state_nxt.held_pressed = 1'b1;
         state_nxt.held_code    = code_new;
         state_nxt.held_mods    = state_cur.flags[MOD_W-1:0];
         rsp.key_valid          = 1'b1;
         rsp.key_press          = 1'b1;
         rsp.key_code           = code_new;
         {rsp.mod_alt, rsp.mod_shift, rsp.mod_ctrl} = state_cur.flags[MOD_W-1:0];
      end

      state_nxt.last_buttons = buttons;
      rsp.hint_button        = state_nxt.shown_hint;
      rsp.layer_now          = state_nxt.layer;
   end

endmodule
